>>> rtl/core/link_frame_receive_parser_defines.svh
// Assertion macros used by the link frame receive parser top level.
`ifndef LINK_FRAME_RECEIVE_PARSER_DEFINES_SVH
`define LINK_FRAME_RECEIVE_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

`define LFRP_ASSERT_NOW(label, clk, rst, cond, consq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consq)) \
    else $error("link frame parser assertion failed");

`define LFRP_ASSERT_NEXT(label, clk, rst, cond, consq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consq)) \
    else $error("link frame parser assertion failed");

`else

`define LFRP_ASSERT_NOW(label, clk, rst, cond, consq)

`define LFRP_ASSERT_NEXT(label, clk, rst, cond, consq)

`endif

`endif

>>> rtl/core/lfrp_pkg.sv
// Package with the types, constants and layout of the link frame receive parser.
`default_nettype none

package lfrp_pkg;

  localparam int ADDR_BYTES     = 6;
  localparam int PREAMBLE_BYTES = 2;

  localparam int BYTE_W    = 8;
  localparam int ADDR_W    = 48;
  localparam int LEN_W     = 16;
  localparam int COUNT_W   = 17;
  localparam int CFG_IDX_W = 3;

  localparam int POS_TYPE = PREAMBLE_BYTES;
  localparam int POS_SRC  = POS_TYPE + 1;
  localparam int POS_DST  = POS_SRC + ADDR_BYTES;
  localparam int POS_LEN  = POS_DST + ADDR_BYTES;
  localparam int HDR_LEN  = POS_LEN + 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [ADDR_W-1:0] OWN_ADDRESS_RESET       = '0;
  localparam logic [ADDR_W-1:0] BROADCAST_ADDRESS_RESET = '1;
  localparam logic [BYTE_W-1:0] PREAMBLE_FIRST_RESET    = 8'hAA;
  localparam logic [BYTE_W-1:0] PREAMBLE_SECOND_RESET   = 8'h55;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET       = 16'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDRESS       = 3'd0,
    CFG_BROADCAST_ADDRESS = 3'd1,
    CFG_PREAMBLE_FIRST    = 3'd2,
    CFG_PREAMBLE_SECOND   = 3'd3,
    CFG_MAX_PAYLOAD       = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    VERDICT_OK            = 3'd0,
    VERDICT_NOT_MINE      = 3'd1,
    VERDICT_TOO_SHORT     = 3'd2,
    VERDICT_BAD_PREAMBLE  = 3'd3,
    VERDICT_OVER_MTU      = 3'd4,
    VERDICT_SIZE_MISMATCH = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [ADDR_W-1:0] own_address;
    logic [ADDR_W-1:0] broadcast_address;
    logic [BYTE_W-1:0] preamble_first;
    logic [BYTE_W-1:0] preamble_second;
    logic [LEN_W-1:0]  max_payload;
  } lfrp_cfg_t;

  // Everything one received byte gives: an optional payload beat, an optional
  // verdict beat and the header fields that both carry.
  typedef struct packed {
    logic              has_payload;
    logic [BYTE_W-1:0] payload_byte;
    logic              has_verdict;
    verdict_t          verdict;
    logic [BYTE_W-1:0] frame_type;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic [LEN_W-1:0]  payload_length;
  } lfrp_rec_t;

endpackage

`default_nettype wire

>>> rtl/core/lfrp_in_if.sv
// Receive byte channel interface.
`default_nettype none

interface lfrp_in_if;
  logic                       valid;
  logic                       ready;
  logic [lfrp_pkg::BYTE_W-1:0] rx_byte;
  logic                       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lfrp_out_if.sv
// Result channel interface.
`default_nettype none

interface lfrp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lfrp_pkg::BYTE_W-1:0] payload_byte;
  logic [2:0]                  verdict;
  logic [lfrp_pkg::BYTE_W-1:0] frame_type;
  logic [lfrp_pkg::ADDR_W-1:0] source_address;
  logic [lfrp_pkg::ADDR_W-1:0] dest_address;
  logic [lfrp_pkg::LEN_W-1:0]  payload_length;
  logic                        last_of_run;

  modport source (output valid, output kind, output payload_byte, output verdict,
                  output frame_type, output source_address, output dest_address,
                  output payload_length, output last_of_run, input ready);
  modport sink (input valid, input kind, input payload_byte, input verdict,
                input frame_type, input source_address, input dest_address,
                input payload_length, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lfrp_cfg_if.sv
// Configuration write channel interface.
`default_nettype none

interface lfrp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfrp_pkg::CFG_IDX_W-1:0] index;
  logic [lfrp_pkg::ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/link_frame_receive_parser.sv
// Top level of the link frame receive parser.
//
// The rx channel takes one received byte per beat, with frame_end set on the
// final byte of a frame. Header bytes are captured, each byte past the header
// leaves as a payload result, and the final byte also gives one verdict result.
// The cfg channel writes the address, preamble and MTU registers; it is always
// ready. The user writes it only while no frame is in flight; the block itself
// does not enforce this. A result is registered in the result queue when its
// byte is taken. Throughput is one byte per cycle while the queue has space.
// Header bytes give no result, and the final byte of a frame with a payload
// gives two result beats, so that byte holds the result channel for both beats.
// A two-record queue between the parser and the result channel absorbs a
// stall: rx stays ready while at most one record waits, and drops ready only
// when both records are held.
// Reset clears the byte counter, the captured header and the queue, and
// returns the registers to own address zero, broadcast all ones, preamble
// 0xAA 0x55 and an MTU of 1500.
`default_nettype none

`include "link_frame_receive_parser_defines.svh"

module link_frame_receive_parser (
  input  logic       clk,
  input  logic       rst,
  lfrp_in_if.sink    rx,
  lfrp_out_if.source result,
  lfrp_cfg_if.sink   cfg
);
  import lfrp_pkg::*;

  lfrp_cfg_t regs;
  lfrp_rec_t rec;
  logic      push;
  logic      space;
  logic      accept;

  assign rx.ready = space;
  assign accept   = rx.valid && rx.ready;

  lfrp_config u_config (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lfrp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .frame_end (rx.frame_end),
    .regs      (regs),
    .push      (push),
    .rec       (rec)
  );

  lfrp_result_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .rec   (rec),
    .space (space),
    .res   (result)
  );

  `LFRP_ASSERT_NEXT(a_end_gives_result, clk, rst, accept && rx.frame_end, result.valid)
  `LFRP_ASSERT_NEXT(a_verdict_follows_payload, clk, rst, result.valid && result.ready && !result.kind && !result.last_of_run, result.valid && result.kind)
  `LFRP_ASSERT_NOW(a_stall_only_when_full, clk, rst, !rx.ready, result.valid)

endmodule

`default_nettype wire

>>> rtl/core/lfrp_config.sv
// Configuration register file of the link frame receive parser.
`default_nettype none

module lfrp_config (
  input  logic                clk,
  input  logic                rst,
  lfrp_cfg_if.sink            cfg,
  output lfrp_pkg::lfrp_cfg_t regs
);
  import lfrp_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.own_address       <= OWN_ADDRESS_RESET;
      regs.broadcast_address <= BROADCAST_ADDRESS_RESET;
      regs.preamble_first    <= PREAMBLE_FIRST_RESET;
      regs.preamble_second   <= PREAMBLE_SECOND_RESET;
      regs.max_payload       <= MAX_PAYLOAD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_OWN_ADDRESS:       regs.own_address       <= cfg.data;
        CFG_BROADCAST_ADDRESS: regs.broadcast_address <= cfg.data;
        CFG_PREAMBLE_FIRST:    regs.preamble_first    <= cfg.data[BYTE_W-1:0];
        CFG_PREAMBLE_SECOND:   regs.preamble_second   <= cfg.data[BYTE_W-1:0];
        CFG_MAX_PAYLOAD:       regs.max_payload       <= cfg.data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lfrp_parser.sv
// Header capture, byte counting and end-of-frame verdict for one received byte.
`default_nettype none

module lfrp_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [lfrp_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        frame_end,
  input  lfrp_pkg::lfrp_cfg_t         regs,
  output logic                        push,
  output lfrp_pkg::lfrp_rec_t         rec
);
  import lfrp_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic [LEN_W-1:0]   preamble_seen;
  logic [BYTE_W-1:0]  type_reg;
  logic [ADDR_W-1:0]  source_reg;
  logic [ADDR_W-1:0]  dest_reg;
  logic [LEN_W-1:0]   length_reg;

  logic [COUNT_W-1:0] byte_count_next;
  logic [LEN_W-1:0]   preamble_seen_next;
  logic [BYTE_W-1:0]  type_reg_next;
  logic [ADDR_W-1:0]  source_reg_next;
  logic [ADDR_W-1:0]  dest_reg_next;
  logic [LEN_W-1:0]   length_reg_next;
  logic               in_payload;
  logic [COUNT_W-1:0] expected_size;
  verdict_t           verdict;

  always_comb begin
    preamble_seen_next = preamble_seen;
    type_reg_next      = type_reg;
    source_reg_next    = source_reg;
    dest_reg_next      = dest_reg;
    length_reg_next    = length_reg;
    in_payload         = 1'b0;
    priority if (byte_count < COUNT_W'(POS_TYPE)) begin
      preamble_seen_next = {preamble_seen[LEN_W-BYTE_W-1:0], rx_byte};
    end else if (byte_count == COUNT_W'(POS_TYPE)) begin
      type_reg_next = rx_byte;
    end else if (byte_count < COUNT_W'(POS_DST)) begin
      source_reg_next = {source_reg[ADDR_W-BYTE_W-1:0], rx_byte};
    end else if (byte_count < COUNT_W'(POS_LEN)) begin
      dest_reg_next = {dest_reg[ADDR_W-BYTE_W-1:0], rx_byte};
    end else if (byte_count < COUNT_W'(HDR_LEN)) begin
      length_reg_next = {length_reg[LEN_W-BYTE_W-1:0], rx_byte};
    end else begin
      in_payload = 1'b1;
    end
  end

  assign byte_count_next = (byte_count == COUNT_MAX) ? byte_count
                                                     : byte_count + COUNT_W'(1);
  assign expected_size   = COUNT_W'(HDR_LEN) + {1'b0, length_reg_next};

  always_comb begin
    priority if (byte_count_next < COUNT_W'(HDR_LEN)) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (preamble_seen_next != {regs.preamble_first, regs.preamble_second}) begin
      verdict = VERDICT_BAD_PREAMBLE;
    end else if (length_reg_next > regs.max_payload) begin
      verdict = VERDICT_OVER_MTU;
    end else if (byte_count_next != expected_size) begin
      verdict = VERDICT_SIZE_MISMATCH;
    end else if (dest_reg_next != regs.own_address &&
                 dest_reg_next != regs.broadcast_address) begin
      verdict = VERDICT_NOT_MINE;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  assign push = accept && (in_payload || frame_end);

  always_comb begin
    rec.has_payload    = in_payload;
    rec.payload_byte   = rx_byte;
    rec.has_verdict    = frame_end;
    rec.verdict        = verdict;
    rec.frame_type     = type_reg_next;
    rec.source_address = source_reg_next;
    rec.dest_address   = dest_reg_next;
    rec.payload_length = length_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      preamble_seen <= '0;
      type_reg      <= '0;
      source_reg    <= '0;
      dest_reg      <= '0;
      length_reg    <= '0;
    end else if (accept) begin
      if (frame_end) begin
        byte_count    <= '0;
        preamble_seen <= '0;
        type_reg      <= '0;
        source_reg    <= '0;
        dest_reg      <= '0;
        length_reg    <= '0;
      end else begin
        byte_count    <= byte_count_next;
        preamble_seen <= preamble_seen_next;
        type_reg      <= type_reg_next;
        source_reg    <= source_reg_next;
        dest_reg      <= dest_reg_next;
        length_reg    <= length_reg_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lfrp_result_queue.sv
// Two-record result queue that splits each record into its result beats.
`default_nettype none

module lfrp_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lfrp_pkg::lfrp_rec_t rec,
  output logic                space,
  lfrp_out_if.source          res
);
  import lfrp_pkg::*;

  lfrp_rec_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       payload_sent;

  lfrp_rec_t  head;
  logic       head_is_verdict;
  logic       beat;
  logic       pop;

  assign head            = entries[rd_ptr];
  assign head_is_verdict = !head.has_payload || payload_sent;
  assign space           = (count != 2'd2);

  assign res.valid          = (count != 2'd0);
  assign res.kind           = head_is_verdict;
  assign res.payload_byte   = head_is_verdict ? '0 : head.payload_byte;
  assign res.verdict        = head_is_verdict ? head.verdict : VERDICT_OK;
  assign res.frame_type     = head.frame_type;
  assign res.source_address = head.source_address;
  assign res.dest_address   = head.dest_address;
  assign res.payload_length = head.payload_length;
  assign res.last_of_run    = head_is_verdict || !head.has_verdict;

  assign beat = res.valid && res.ready;
  assign pop  = beat && res.last_of_run;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= 1'b0;
      rd_ptr       <= 1'b0;
      count        <= 2'd0;
      payload_sent <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr       <= !rd_ptr;
        payload_sent <= 1'b0;
      end else if (beat) begin
        payload_sent <= 1'b1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

>>> tb/link_frame_receive_parser_test.sv
// Self-checking testbench for the link frame receive parser with a byte-level frame predictor.
`default_nettype none

module link_frame_receive_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrp_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [2:0]        verdict;
    logic [BYTE_W-1:0] frame_type;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic [LEN_W-1:0]  payload_length;
    logic              last_of_run;
  } result_beat_t;

  class frame_result_tracker;
    logic [ADDR_W-1:0]  own_address;
    logic [ADDR_W-1:0]  broadcast_address;
    logic [BYTE_W-1:0]  preamble_first;
    logic [BYTE_W-1:0]  preamble_second;
    logic [LEN_W-1:0]   max_payload;
    logic [COUNT_W-1:0] byte_count;
    logic [15:0]        preamble_seen;
    logic [BYTE_W-1:0]  type_reg;
    logic [ADDR_W-1:0]  source_reg;
    logic [ADDR_W-1:0]  dest_reg;
    logic [LEN_W-1:0]   length_reg;
    result_beat_t       awaited[$];
    int                 mismatches;

    function new();
      own_address       = OWN_ADDRESS_RESET;
      broadcast_address = BROADCAST_ADDRESS_RESET;
      preamble_first    = PREAMBLE_FIRST_RESET;
      preamble_second   = PREAMBLE_SECOND_RESET;
      max_payload       = MAX_PAYLOAD_RESET;
      mismatches        = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count    = '0;
      preamble_seen = '0;
      type_reg      = '0;
      source_reg    = '0;
      dest_reg      = '0;
      length_reg    = '0;
    endfunction

    function void write_register(cfg_index_t idx, logic [ADDR_W-1:0] value);
      case (idx)
        CFG_OWN_ADDRESS:       own_address = value;
        CFG_BROADCAST_ADDRESS: broadcast_address = value;
        CFG_PREAMBLE_FIRST:    preamble_first = value[BYTE_W-1:0];
        CFG_PREAMBLE_SECOND:   preamble_second = value[BYTE_W-1:0];
        CFG_MAX_PAYLOAD:       max_payload = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_beat(logic kind, logic [BYTE_W-1:0] pbyte, verdict_t verdict,
                            logic last);
      result_beat_t beat;
      beat.kind           = kind;
      beat.payload_byte   = pbyte;
      beat.verdict        = verdict;
      beat.frame_type     = type_reg;
      beat.source_address = source_reg;
      beat.dest_address   = dest_reg;
      beat.payload_length = length_reg;
      beat.last_of_run    = last;
      awaited.push_back(beat);
    endfunction

    function void accept_byte(logic [BYTE_W-1:0] b, logic last);
      verdict_t verdict;
      if (byte_count < POS_TYPE) begin
        preamble_seen = {preamble_seen[7:0], b};
      end else if (byte_count == POS_TYPE) begin
        type_reg = b;
      end else if (byte_count < POS_DST) begin
        source_reg = {source_reg[ADDR_W-9:0], b};
      end else if (byte_count < POS_LEN) begin
        dest_reg = {dest_reg[ADDR_W-9:0], b};
      end else if (byte_count < HDR_LEN) begin
        length_reg = {length_reg[7:0], b};
      end else begin
        push_beat(1'b0, b, VERDICT_OK, !last);
      end
      if (byte_count != COUNT_MAX) byte_count++;
      if (last) begin
        if (byte_count < HDR_LEN) verdict = VERDICT_TOO_SHORT;
        else if (preamble_seen != {preamble_first, preamble_second})
          verdict = VERDICT_BAD_PREAMBLE;
        else if (length_reg > max_payload) verdict = VERDICT_OVER_MTU;
        else if (int'(byte_count) != HDR_LEN + int'(length_reg))
          verdict = VERDICT_SIZE_MISMATCH;
        else if (dest_reg != own_address && dest_reg != broadcast_address)
          verdict = VERDICT_NOT_MINE;
        else verdict = VERDICT_OK;
        push_beat(1'b1, '0, verdict, 1'b1);
        clear_frame();
      end
    endfunction

    function void compare_field(string name, logic [ADDR_W-1:0] want,
                                logic [ADDR_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(result_beat_t got);
      result_beat_t want;
      if (awaited.size() == 0) begin
        $error("result beat of kind %0d arrived with nothing expected", got.kind);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("frame_type", want.frame_type, got.frame_type);
      compare_field("source_address", want.source_address, got.source_address);
      compare_field("dest_address", want.dest_address, got.dest_address);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   feed_gaps;
  bit   drain_gaps;
  int   bytes_sent;

  frame_result_tracker tracker;

  lfrp_in_if  rx_if ();
  lfrp_out_if res_if ();
  lfrp_cfg_if cfg_if ();

  link_frame_receive_parser u_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = feed_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid     <= 1'b1;
    rx_if.rx_byte   <= b;
    rx_if.frame_end <= last;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    tracker.accept_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drive_frame(input logic [7:0] pre_a, input logic [7:0] pre_b,
                             input logic [ADDR_W-1:0] dst, input logic [LEN_W-1:0] len_field,
                             input int total, input bit extremes);
    logic [7:0]        hdr [HDR_LEN];
    logic [ADDR_W-1:0] src;
    int                i;
    src           = rand48();
    hdr[0]        = pre_a;
    hdr[1]        = pre_b;
    hdr[POS_TYPE] = 8'($urandom);
    for (i = 0; i < ADDR_BYTES; i++) begin
      hdr[POS_SRC + i] = src[8*(ADDR_BYTES-1-i) +: 8];
      hdr[POS_DST + i] = dst[8*(ADDR_BYTES-1-i) +: 8];
    end
    hdr[POS_LEN]     = len_field[15:8];
    hdr[POS_LEN + 1] = len_field[7:0];
    for (i = 0; i < total; i++) begin
      if (i < HDR_LEN) send_byte(hdr[i], i == total - 1);
      else if (extremes) send_byte((i - HDR_LEN) % 2 ? 8'hFF : 8'h00, i == total - 1);
      else send_byte(8'($urandom), i == total - 1);
    end
  endtask

  task automatic send_random_frame();
    logic [7:0]        pa;
    logic [7:0]        pb;
    logic [ADDR_W-1:0] dst;
    logic [LEN_W-1:0]  len;
    int                total;
    int                shape;
    feed_gaps  = $urandom_range(0, 3) != 0;
    drain_gaps = $urandom_range(0, 3) != 0;
    pa = tracker.preamble_first;
    pb = tracker.preamble_second;
    case ($urandom_range(0, 3))
      0: dst = tracker.own_address;
      1: dst = tracker.broadcast_address;
      2: dst = rand48();
      default: dst = tracker.own_address ^ (48'd1 << $urandom_range(0, 47));
    endcase
    len   = 16'($urandom_range(0, 12));
    total = HDR_LEN + int'(len);
    shape = $urandom_range(0, 9);
    if (shape == 6) begin
      if ($urandom_range(0, 1)) pa ^= 8'(1 << $urandom_range(0, 7));
      else pb ^= 8'(1 << $urandom_range(0, 7));
    end else if (shape == 7) begin
      if ($urandom_range(0, 1)) begin
        len   = 16'($urandom);
        total = HDR_LEN + $urandom_range(0, 12);
      end else begin
        total = total + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 3);
        if (total < 1) total = 1;
      end
    end else if (shape == 8) begin
      total = $urandom_range(1, HDR_LEN - 1);
    end else if (shape == 9) begin
      pa    = 8'($urandom);
      pb    = 8'($urandom);
      dst   = rand48();
      len   = 16'($urandom);
      total = $urandom_range(1, 30);
    end
    drive_frame(pa, pb, dst, len, total, 1'b0);
  endtask

  task automatic run_frames(input int count);
    int first_byte;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < count) send_random_frame();
  endtask

  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [ADDR_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    tracker.write_register(idx, value);
    @(negedge clk);
  endtask

  task automatic program_registers(input logic [ADDR_W-1:0] own, input logic [ADDR_W-1:0] bcast,
                                   input logic [7:0] pre_a, input logic [7:0] pre_b,
                                   input logic [LEN_W-1:0] mtu);
    wait_idle();
    write_register(CFG_OWN_ADDRESS, own);
    write_register(CFG_BROADCAST_ADDRESS, bcast);
    write_register(CFG_PREAMBLE_FIRST, {40'd0, pre_a});
    write_register(CFG_PREAMBLE_SECOND, {40'd0, pre_b});
    write_register(CFG_MAX_PAYLOAD, {32'd0, mtu});
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: random stalls per beat, each accepted beat checked in order.
  initial begin
    result_beat_t got;
    int           gap;
    res_if.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = drain_gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      got.kind           = res_if.kind;
      got.payload_byte   = res_if.payload_byte;
      got.verdict        = res_if.verdict;
      got.frame_type     = res_if.frame_type;
      got.source_address = res_if.source_address;
      got.dest_address   = res_if.dest_address;
      got.payload_length = res_if.payload_length;
      got.last_of_run    = res_if.last_of_run;
      tracker.check_beat(got);
      @(negedge clk);
    end
  end

  initial begin
    rst             = 1'b1;
    rx_if.valid     = 1'b0;
    rx_if.rx_byte   = '0;
    rx_if.frame_end = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_OWN_ADDRESS;
    cfg_if.data     = '0;
    feed_gaps       = 1'b1;
    drain_gaps      = 1'b1;
    bytes_sent      = 0;
    tracker         = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A one-byte frame, then a good broadcast frame whose final byte is payload.
    drive_frame(PREAMBLE_FIRST_RESET, PREAMBLE_SECOND_RESET, BROADCAST_ADDRESS_RESET, 16'd2,
                1, 1'b1);
    drive_frame(PREAMBLE_FIRST_RESET, PREAMBLE_SECOND_RESET, BROADCAST_ADDRESS_RESET, 16'd2,
                HDR_LEN + 2, 1'b1);
    run_frames(80);

    program_registers(rand48(), '0, 8'h00, 8'hFF, 16'd0);
    run_frames(80);
    program_registers('1, rand48(), 8'($urandom), 8'($urandom), 16'hFFFF);
    run_frames(80);
    program_registers('0, '1, 8'hFF, 8'h00, 16'($urandom_range(3, 12)));
    run_frames(80);
    program_registers(rand48(), rand48(), PREAMBLE_FIRST_RESET, PREAMBLE_SECOND_RESET,
                      16'hFFFF);
    run_frames(80);

    wait_idle();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
